[sv/pcgs_pkg.sv]
// Package for the Polish charset guess scorer: item structs, encoding codes,
// the letter code tables and the weight lookup function.
// No dependencies.
`default_nettype none

package pcgs_pkg;

  localparam int NUM_ENC     = 3;
  localparam int NUM_LETTERS = 18;
  localparam int WEIGHT_W    = 5;
  localparam int SCORE_OUT_W = 24;

  typedef enum logic [1:0] {
    ENC_ISO = 2'd0,
    ENC_WIN = 2'd1,
    ENC_DOS = 2'd2
  } enc_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [1:0]             chosen_encoding;
    logic                   evidence_found;
    logic [SCORE_OUT_W-1:0] score_iso;
    logic [SCORE_OUT_W-1:0] score_win;
    logic [SCORE_OUT_W-1:0] score_dos;
  } out_item_t;

  // Polish letter codes: rows are ISO8859-2, CP1250 and CP852.
  localparam logic [7:0] LETTER_CODES [NUM_ENC][NUM_LETTERS] = '{
    '{8'd161, 8'd198, 8'd202, 8'd163, 8'd209, 8'd211, 8'd166, 8'd172, 8'd175,
      8'd177, 8'd230, 8'd234, 8'd179, 8'd241, 8'd243, 8'd182, 8'd188, 8'd191},
    '{8'd165, 8'd198, 8'd202, 8'd163, 8'd209, 8'd211, 8'd140, 8'd143, 8'd175,
      8'd185, 8'd230, 8'd234, 8'd179, 8'd241, 8'd243, 8'd156, 8'd159, 8'd191},
    '{8'd164, 8'd143, 8'd168, 8'd157, 8'd227, 8'd224, 8'd151, 8'd141, 8'd189,
      8'd165, 8'd134, 8'd169, 8'd136, 8'd228, 8'd162, 8'd152, 8'd171, 8'd190}
  };

  localparam logic [WEIGHT_W-1:0] LETTER_WEIGHT [NUM_LETTERS] = '{
    5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1, 5'd1,
    5'd15, 5'd10, 5'd16, 5'd19, 5'd1, 5'd13, 5'd13, 5'd1, 5'd18
  };

  // Weight of the byte for one encoding, zero if it is no Polish letter there.
  // The scan runs downward so that the lowest matching position wins.
  function automatic logic [WEIGHT_W-1:0] letter_weight(input int unsigned enc,
                                                         input logic [7:0] b);
    logic [WEIGHT_W-1:0] w;
    w = '0;
    for (int j = NUM_LETTERS - 1; j >= 0; j--) begin
      if (LETTER_CODES[enc][j] == b) begin
        w = LETTER_WEIGHT[j];
      end
    end
    return w;
  endfunction

endpackage

`default_nettype wire

[sv/pcgs_score_acc.sv]
// One saturating score accumulator for a single candidate encoding.
// Depends on pcgs_pkg for the weight width.
`default_nettype none

module pcgs_score_acc
  import pcgs_pkg::*;
#(
  parameter int SCORE_BITS = 24
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  advance,
  input  wire logic                  clear,
  input  wire logic [WEIGHT_W-1:0]   weight,
  output logic      [SCORE_BITS-1:0] score_upd
);

  logic [SCORE_BITS-1:0] score_r;
  logic [SCORE_BITS-1:0] score_nxt;
  logic [SCORE_BITS:0]   sum;

  assign sum = {1'b0, score_r} + {{(SCORE_BITS + 1 - WEIGHT_W){1'b0}}, weight};

  // A carry out of the top bit means the score would pass its maximum.
  assign score_upd = sum[SCORE_BITS] ? {SCORE_BITS{1'b1}} : sum[SCORE_BITS-1:0];
  assign score_nxt = clear ? '0 : score_upd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      score_r <= '0;
    end else if (advance) begin
      score_r <= score_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/polish_charset_guess_scorer_core.sv]
// Top level of the Polish charset guess scorer: input register, three score
// accumulators, best-score selection and the result register.
// Depends on pcgs_pkg and pcgs_score_acc.
//
//   channel | ports                         | moves
//   --------+-------------------------------+-----------------------------------
//   input   | in_valid, in_stall, in_data   | at most one message byte per transaction
//   result  | out_valid, out_stall, out_data| scores and choice, once per message
//
// One byte is taken every cycle while in_stall is low; a last byte passes from the
// input register into the result register, where its result is presented.
// The score update is a single add-and-saturate per encoding feeding back into
// its own register, which sets the one-cycle rate.
// After reset all scores are zero and both registers are empty. A stalled
// result holds back only a last byte; other bytes keep flowing into the scores.
`default_nettype none

module polish_charset_guess_scorer_core
  import pcgs_pkg::*;
#(
  parameter int SCORE_BITS = 24
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);

  logic                  in_valid_r;
  in_item_t              in_data_r;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  out_item_t             out_data_nxt;
  logic                  advance;
  logic                  emit;

  logic [SCORE_BITS-1:0]  score_upd [NUM_ENC];
  logic [SCORE_OUT_W-1:0] score_out [NUM_ENC];

  logic [SCORE_BITS-1:0] best01;
  logic [1:0]            sel01;
  logic [SCORE_BITS-1:0] best;
  logic [1:0]            sel;

  // A last byte must wait while the result register is full and stalled.
  assign advance  = in_valid_r &&
                    (!in_data_r.last_byte || !out_valid_r || !out_stall);
  assign emit     = advance && in_data_r.last_byte;
  assign in_stall = in_valid_r && !advance;

  for (genvar e = 0; e < NUM_ENC; e++) begin : g_enc
    logic [WEIGHT_W-1:0] weight;

    assign weight = in_data_r.has_byte ?
                    letter_weight(e, in_data_r.data_byte) : '0;

    pcgs_score_acc #(
      .SCORE_BITS (SCORE_BITS)
    ) u_acc (
      .clk       (clk),
      .rst_n     (rst_n),
      .advance   (advance),
      .clear     (in_data_r.last_byte),
      .weight    (weight),
      .score_upd (score_upd[e])
    );

    if (SCORE_BITS >= SCORE_OUT_W) begin : g_trunc
      assign score_out[e] = score_upd[e][SCORE_OUT_W-1:0];
    end else begin : g_ext
      assign score_out[e] = {{(SCORE_OUT_W - SCORE_BITS){1'b0}}, score_upd[e]};
    end
  end

  // Strict compares keep the lower index on ties.
  always_comb begin
    if (score_upd[1] > score_upd[0]) begin
      best01 = score_upd[1];
      sel01  = ENC_WIN;
    end else begin
      best01 = score_upd[0];
      sel01  = ENC_ISO;
    end
    if (score_upd[2] > best01) begin
      best = score_upd[2];
      sel  = ENC_DOS;
    end else begin
      best = best01;
      sel  = sel01;
    end
    out_data_nxt.chosen_encoding = sel;
    out_data_nxt.evidence_found  = (best != '0);
    out_data_nxt.score_iso       = score_out[0];
    out_data_nxt.score_win       = score_out[1];
    out_data_nxt.score_dos       = score_out[2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        in_valid_r <= in_valid;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_data_r <= in_data;
    end
    if (emit) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

[sv/pcgs_checker.sv]
// Port-level checks for the Polish charset guess scorer, bound to the top.
// Depends on pcgs_pkg and polish_charset_guess_scorer_core.
`default_nettype none

module pcgs_checker
  import pcgs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      in_valid,
  input wire logic      in_stall,
  input wire in_item_t  in_data,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire out_item_t out_data
);

  // A stalled result transaction keeps its valid and its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // The input side is held back only by a full, stalled result register.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without a stalled result");

  // A result that rises on an empty output was started by a last byte accepted
  // into the input register and passed on from there to the result register.
  a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && !in_stall && in_data.last_byte, 2))
    else $error("result without a last byte");

  // Without evidence every score is zero.
  a_no_evidence: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.evidence_found |->
      out_data.score_iso == '0 && out_data.score_win == '0 &&
      out_data.score_dos == '0)
    else $error("nonzero score without evidence");

endmodule

bind polish_charset_guess_scorer_core pcgs_checker u_pcgs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
